// ===== design/iou_pkg.sv =====
package iou_pkg;

  // Field widths of the request and the result.
  localparam int unsigned CoordBits = 16;
  localparam int unsigned IouBits   = 16;

  // Edges at twice the coordinate scale: 2c - s and 2c + s, signed.
  localparam int unsigned EdgeBits  = CoordBits + 3;
  // Overlap on one axis, signed; a positive overlap fits in CoordBits + 1 bits.
  localparam int unsigned OvlBits   = CoordBits + 4;
  localparam int unsigned PosBits   = CoordBits + 1;
  // Product of the two positive overlaps (intersection at four times the area scale).
  localparam int unsigned InterBits = 2 * PosBits;
  // Product of one box's width and height.
  localparam int unsigned ProdBits  = 2 * CoordBits;
  // Sum of both areas, then the union at four times the area scale.
  localparam int unsigned SumBits   = ProdBits + 1;
  localparam int unsigned AreaBits  = SumBits + 2;
  // Partial remainder of the division stays below twice the union.
  localparam int unsigned RemBits   = AreaBits + 1;
  localparam int unsigned QuotBits  = IouBits + 1;

  typedef struct packed {
    logic [CoordBits-1:0] a_center_x;
    logic [CoordBits-1:0] a_center_y;
    logic [CoordBits-1:0] a_width;
    logic [CoordBits-1:0] a_height;
    logic [CoordBits-1:0] b_center_x;
    logic [CoordBits-1:0] b_center_y;
    logic [CoordBits-1:0] b_width;
    logic [CoordBits-1:0] b_height;
  } box_req_t;

  typedef struct packed {
    logic [IouBits:0] iou;
    logic             zero_union;
  } iou_rsp_t;

  // Overlaps together with the sizes that the area stage needs.
  typedef struct packed {
    logic signed [OvlBits-1:0] ox;
    logic signed [OvlBits-1:0] oy;
    logic [CoordBits-1:0]      aw;
    logic [CoordBits-1:0]      ah;
    logic [CoordBits-1:0]      bw;
    logic [CoordBits-1:0]      bh;
  } ovl_t;

  // State of one item as it moves through the divider.
  typedef struct packed {
    logic [RemBits-1:0]  rem;
    logic [AreaBits-1:0] dvs;
    logic [QuotBits-1:0] quot;
    logic                zero;
  } div_t;

endpackage

// ===== design/iou_overlap.sv =====
module iou_overlap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  iou_pkg::box_req_t req_i,
  output logic              valid_o,
  input  logic              ready_i,
  output iou_pkg::ovl_t     ovl_o
);
  import iou_pkg::*;

  typedef struct packed {
    logic signed [EdgeBits-1:0] l1x, r1x, l2x, r2x;
    logic signed [EdgeBits-1:0] l1y, r1y, l2y, r2y;
    logic [CoordBits-1:0]       aw, ah, bw, bh;
  } edge_t;

  edge_t edge_d, edge_q;
  logic  v1_q, v2_q, rdy1, rdy2;
  ovl_t  ovl_d, ovl_q;

  function automatic logic signed [EdgeBits-1:0] lo_edge(logic [CoordBits-1:0] c,
                                                         logic [CoordBits-1:0] s);
    lo_edge = $signed({2'b00, c, 1'b0}) - $signed({3'b000, s});
  endfunction

  function automatic logic signed [EdgeBits-1:0] hi_edge(logic [CoordBits-1:0] c,
                                                         logic [CoordBits-1:0] s);
    hi_edge = $signed({2'b00, c, 1'b0}) + $signed({3'b000, s});
  endfunction

  function automatic logic signed [OvlBits-1:0] overlap(logic signed [EdgeBits-1:0] l1,
                                                        logic signed [EdgeBits-1:0] r1,
                                                        logic signed [EdgeBits-1:0] l2,
                                                        logic signed [EdgeBits-1:0] r2);
    logic signed [EdgeBits-1:0] lft, rgt;
    lft = (l1 > l2) ? l1 : l2;
    rgt = (r1 < r2) ? r1 : r2;
    overlap = OvlBits'(rgt) - OvlBits'(lft);
  endfunction

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign ovl_o   = ovl_q;

  always_comb begin
    edge_d.l1x = lo_edge(req_i.a_center_x, req_i.a_width);
    edge_d.r1x = hi_edge(req_i.a_center_x, req_i.a_width);
    edge_d.l2x = lo_edge(req_i.b_center_x, req_i.b_width);
    edge_d.r2x = hi_edge(req_i.b_center_x, req_i.b_width);
    edge_d.l1y = lo_edge(req_i.a_center_y, req_i.a_height);
    edge_d.r1y = hi_edge(req_i.a_center_y, req_i.a_height);
    edge_d.l2y = lo_edge(req_i.b_center_y, req_i.b_height);
    edge_d.r2y = hi_edge(req_i.b_center_y, req_i.b_height);
    edge_d.aw  = req_i.a_width;
    edge_d.ah  = req_i.a_height;
    edge_d.bw  = req_i.b_width;
    edge_d.bh  = req_i.b_height;
  end

  always_comb begin
    ovl_d.ox = overlap(edge_q.l1x, edge_q.r1x, edge_q.l2x, edge_q.r2x);
    ovl_d.oy = overlap(edge_q.l1y, edge_q.r1y, edge_q.l2y, edge_q.r2y);
    ovl_d.aw = edge_q.aw;
    ovl_d.ah = edge_q.ah;
    ovl_d.bw = edge_q.bw;
    ovl_d.bh = edge_q.bh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) edge_q <= edge_d;
    if (rdy2 && v1_q) ovl_q <= ovl_d;
  end

endmodule

// ===== design/iou_area.sv =====
module iou_area (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  iou_pkg::ovl_t ovl_i,
  output logic          valid_o,
  input  logic          ready_i,
  output iou_pkg::div_t div_o
);
  import iou_pkg::*;

  logic                 v3_q, v4_q, v5_q, rdy3, rdy4, rdy5;
  logic                 hit;
  logic [InterBits-1:0] inter_d, inter3_q, inter4_q;
  logic [ProdBits-1:0]  pa_d, pb_d, pa_q, pb_q;
  logic [SumBits-1:0]   sum_d, sum_q;
  logic [AreaBits-1:0]  union_d;
  div_t                 div_d, div_q;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign ready_o = rdy3;
  assign valid_o = v5_q;
  assign div_o   = div_q;

  // Both overlaps must be non-negative for the boxes to intersect.
  assign hit     = !ovl_i.ox[OvlBits-1] && !ovl_i.oy[OvlBits-1];
  assign inter_d = hit ? ovl_i.ox[PosBits-1:0] * ovl_i.oy[PosBits-1:0] : '0;
  assign pa_d    = ovl_i.aw * ovl_i.ah;
  assign pb_d    = ovl_i.bw * ovl_i.bh;
  assign sum_d   = {1'b0, pa_q} + {1'b0, pb_q};
  assign union_d = {sum_q, 2'b00} - AreaBits'(inter4_q);

  always_comb begin
    div_d.rem  = RemBits'(inter4_q);
    div_d.dvs  = union_d;
    div_d.quot = '0;
    div_d.zero = (union_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= valid_i;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && valid_i) begin
      inter3_q <= inter_d;
      pa_q     <= pa_d;
      pb_q     <= pb_d;
    end
    if (rdy4 && v3_q) begin
      inter4_q <= inter3_q;
      sum_q    <= sum_d;
    end
    if (rdy5 && v4_q) div_q <= div_d;
  end

endmodule

// ===== design/iou_div_stage.sv =====
module iou_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  iou_pkg::div_t div_i,
  output logic          valid_o,
  input  logic          ready_i,
  output iou_pkg::div_t div_o
);
  import iou_pkg::*;

  logic               v_q, rdy, ge;
  logic [RemBits-1:0] rem_sub;
  div_t               div_d, div_q;

  assign rdy     = !v_q || ready_i;
  assign ready_o = rdy;
  assign valid_o = v_q;
  assign div_o   = div_q;

  // One restoring step: one quotient bit per stage.
  assign ge      = div_i.rem >= {1'b0, div_i.dvs};
  assign rem_sub = ge ? div_i.rem - {1'b0, div_i.dvs} : div_i.rem;

  always_comb begin
    div_d      = div_i;
    div_d.rem  = {rem_sub[RemBits-2:0], 1'b0};
    div_d.quot = {div_i.quot[QuotBits-2:0], ge && !div_i.zero};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) div_q <= div_d;
  end

endmodule

// ===== design/box_intersection_over_union.sv =====
// Intersection over union of two axis-aligned boxes, each given as center x,
// center y, width and height in unsigned fixed point. The result is the
// intersection area divided by the union area as unsigned Q1.16, truncated,
// where 65536 means the boxes are identical; when both boxes have zero area
// the union is zero, zero_union is set and iou reads 0. The block is a
// pipeline that accepts one box pair per cycle while the output side is not
// stalled and returns one result per pair, in order: two stages find the
// edges and the overlaps, three stages form the intersection and the two
// areas with their multipliers and the union, and the divider takes one
// stage for each of the 17 quotient bits. Every stage holds its own valid
// bit, so a stalled output only backs up the stages behind it while empty
// stages keep filling, and a new request is taken whenever the first stage
// is empty or moving.
module box_intersection_over_union (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  iou_pkg::box_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output iou_pkg::iou_rsp_t rsp_o
);
  import iou_pkg::*;

  logic          ovl_valid, ovl_ready;
  ovl_t          ovl;
  logic          dv_valid [QuotBits+1];
  logic          dv_ready [QuotBits+1];
  div_t          dv       [QuotBits+1];

  // Edges and per-axis overlaps.
  iou_overlap u_overlap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_i),
    .ready_o (req_ready_o),
    .req_i   (req_i),
    .valid_o (ovl_valid),
    .ready_i (ovl_ready),
    .ovl_o   (ovl)
  );

  // Intersection, areas and union.
  iou_area u_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ovl_valid),
    .ready_o (ovl_ready),
    .ovl_i   (ovl),
    .valid_o (dv_valid[0]),
    .ready_i (dv_ready[0]),
    .div_o   (dv[0])
  );

  // Restoring divider, most significant quotient bit first.
  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    iou_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .ready_o (dv_ready[k]),
      .div_i   (dv[k]),
      .valid_o (dv_valid[k+1]),
      .ready_i (dv_ready[k+1]),
      .div_o   (dv[k+1])
    );
  end

  assign dv_ready[QuotBits] = rsp_ready_i;
  assign rsp_valid_o        = dv_valid[QuotBits];
  assign rsp_o.iou          = dv[QuotBits].quot;
  assign rsp_o.zero_union   = dv[QuotBits].zero;

endmodule

// ===== tb/iou_checker.sv =====
`timescale 1ns / 100ps

module iou_checker
  import iou_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_ready_i,
  input  box_req_t req_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_ready_i,
  input  iou_rsp_t rsp_i,
  output int       mismatches_o,
  output int       outstanding_o
);

  iou_rsp_t expected_iou[$];
  int       mismatches;

  assign mismatches_o = mismatches;

  // Overlap on one axis at twice the coordinate scale; negative when apart.
  function automatic longint axis_overlap(logic [CoordBits-1:0] c1, logic [CoordBits-1:0] s1,
                                          logic [CoordBits-1:0] c2, logic [CoordBits-1:0] s2);
    longint lo1, lo2, hi1, hi2;
    lo1 = 2 * longint'(c1) - longint'(s1);
    hi1 = 2 * longint'(c1) + longint'(s1);
    lo2 = 2 * longint'(c2) - longint'(s2);
    hi2 = 2 * longint'(c2) + longint'(s2);
    return ((hi1 < hi2) ? hi1 : hi2) - ((lo1 > lo2) ? lo1 : lo2);
  endfunction

  function automatic iou_rsp_t predict_iou(box_req_t b);
    longint      ox, oy;
    logic [63:0] inter4, area4, union4, quot;
    iou_rsp_t    r;
    ox = axis_overlap(b.a_center_x, b.a_width, b.b_center_x, b.b_width);
    oy = axis_overlap(b.a_center_y, b.a_height, b.b_center_y, b.b_height);
    inter4 = (ox >= 0 && oy >= 0) ? 64'(ox) * 64'(oy) : 64'd0;
    area4 = 4 * (64'(b.a_width) * 64'(b.a_height) + 64'(b.b_width) * 64'(b.b_height));
    union4 = area4 - inter4;
    if (union4 == 0) begin
      r.iou = '0;
      r.zero_union = 1'b1;
    end else begin
      // The intersection never exceeds the union, so the quotient fits.
      quot = (inter4 << IouBits) / union4;
      r.iou = quot[IouBits:0];
      r.zero_union = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    iou_rsp_t want;
    if (!rst_ni) begin
      expected_iou.delete();
      outstanding_o <= 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        expected_iou.push_back(predict_iou(req_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_iou.size() == 0) begin
          report("unexpected result (iou)", -1, rsp_i.iou);
        end else begin
          want = expected_iou.pop_front();
          if (rsp_i.iou !== want.iou) report("iou", want.iou, rsp_i.iou);
          if (rsp_i.zero_union !== want.zero_union) begin
            report("zero_union", want.zero_union, rsp_i.zero_union);
          end
        end
      end
      outstanding_o <= expected_iou.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import iou_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_ready_o;
  box_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_ready_i;
  iou_rsp_t rsp_o;
  int       mismatches;
  int       outstanding;

  // Largest idle gap per request on each side; changed between phases so
  // that some stretches run back to back and others are full of bubbles.
  int       req_gap_max = 5;
  int       rsp_gap_max = 5;

  box_intersection_over_union u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // The checker sees both channels, predicts every result from the accepted
  // request and compares in order. It only hands back counts.
  iou_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid_i),
    .req_ready_i   (req_ready_o),
    .req_i         (req_i),
    .rsp_valid_i   (rsp_valid_o),
    .rsp_ready_i   (rsp_ready_i),
    .rsp_i         (rsp_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // A hang anywhere ends the run. The limit is set above the slowest legal
  // run, which has roughly eight hundred requests, each with random idling on
  // both sides, plus the pipeline depth.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Waits a random number of cycles, then offers one request and holds it
  // until the block takes it. Valid is only lowered when a gap is drawn, so
  // back-to-back requests keep valid high across the edge.
  task automatic send_pair(logic [CoordBits-1:0] ax, logic [CoordBits-1:0] ay,
                           logic [CoordBits-1:0] aw, logic [CoordBits-1:0] ah,
                           logic [CoordBits-1:0] bx, logic [CoordBits-1:0] by,
                           logic [CoordBits-1:0] bw, logic [CoordBits-1:0] bh);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{a_center_x: ax, a_center_y: ay, a_width: aw, a_height: ah,
               b_center_x: bx, b_center_y: by, b_width: bw, b_height: bh};
    do @(posedge clk_i); while (!(req_valid_i && req_ready_o));
  endtask

  // Box sizes: mostly moderate so that overlaps are common, sometimes
  // anywhere in the full range of the field.
  function automatic logic [CoordBits-1:0] pick_size();
    if ($urandom_range(0, 3) == 0) return CoordBits'($urandom_range(0, 65535));
    return CoordBits'($urandom_range(0, 4095));
  endfunction

  // The result side stalls for a random number of cycles before each
  // result, then waits for the handshake.
  initial begin
    int stall;
    rsp_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rsp_gap_max);
      if (stall > 0) begin
        rsp_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rsp_valid_o && rsp_ready_i));
    end
  end

  initial begin
    logic [CoordBits-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    int kind;

    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests. Both boxes empty at the origin and elsewhere give a
    // zero union; identical boxes give exactly one.
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(16'hFFFF, 16'h1234, 0, 0, 16'h0010, 16'hFFFF, 0, 0);
    send_pair(16'hFFFF, 0, 16'hFFFF, 0, 0, 16'hFFFF, 0, 16'hFFFF);
    send_pair(100, 200, 32, 48, 100, 200, 32, 48);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF);
    send_pair(0, 0, 1, 1, 0, 0, 1, 1);
    // Boxes that touch on one axis only, then on both.
    send_pair(100, 100, 20, 40, 120, 100, 20, 40);
    send_pair(100, 100, 20, 40, 120, 140, 20, 40);
    // Apart on one axis, then apart on both.
    send_pair(100, 100, 20, 40, 500, 100, 20, 40);
    send_pair(100, 100, 20, 40, 500, 900, 20, 40);
    // One box inside the other, and a half overlap.
    send_pair(1000, 1000, 400, 400, 1000, 1000, 100, 100);
    send_pair(1000, 1000, 400, 400, 1200, 1000, 400, 400);
    // One box empty, the other not: zero result, but the union is not zero.
    send_pair(300, 300, 0, 50, 300, 300, 60, 60);
    send_pair(300, 300, 60, 60, 300, 300, 60, 0);
    // Full-size box against nothing; edges running far below zero and above
    // the field range.
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    send_pair(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(16'hFFFF, 0, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
    send_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

    // Random requests, mostly pairs placed near each other so that the
    // overlap arithmetic and the divider see real work.
    for (int n = 0; n < 750; n++) begin
      if (n % 60 == 0) begin
        req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
        rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      end
      kind = $urandom_range(0, 9);
      ax = CoordBits'($urandom_range(0, 65535));
      ay = CoordBits'($urandom_range(0, 65535));
      aw = pick_size();
      ah = pick_size();
      bw = pick_size();
      bh = pick_size();
      bx = CoordBits'($urandom_range(0, 65535));
      by = CoordBits'($urandom_range(0, 65535));
      case (kind)
        0, 1: begin
          // Independent boxes anywhere; usually apart.
        end
        7: begin
          bx = ax; by = ay; bw = aw; bh = ah;
        end
        8: begin
          bx = ax + CoordBits'($urandom_range(0, 64));
          by = ay - CoordBits'($urandom_range(0, 64));
          if ($urandom_range(0, 1)) aw = 0; else ah = 0;
          if ($urandom_range(0, 1)) bh = 0;
        end
        9: begin
          // Edge to edge on x, overlapping on y.
          bw[0] = aw[0];
          bx = ax + CoordBits'((int'(aw) + int'(bw)) / 2);
          by = ay + CoordBits'($urandom_range(0, ah)) - CoordBits'(ah / 2);
        end
        default: begin
          bx = ax + CoordBits'($urandom_range(0, aw)) - CoordBits'(aw / 2);
          by = ay + CoordBits'($urandom_range(0, ah)) - CoordBits'(ah / 2);
        end
      endcase
      send_pair(ax, ay, aw, ah, bx, by, bw, bh);
    end
    req_valid_i <= 1'b0;

    // Drain: wait for every predicted result, then a little longer than the
    // pipeline depth so that a stray extra result would still be caught.
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/iou_pkg.sv
design/iou_overlap.sv
design/iou_area.sv
design/iou_div_stage.sv
design/box_intersection_over_union.sv
tb/iou_checker.sv
tb/tb.sv
